### src/per_cpu_vector_allocator_macros.svh
// ----------------------------------------------------------------------------
// Per-CPU vector allocator assertion macros
// Implication checks sampled on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PER_CPU_VECTOR_ALLOCATOR_MACROS_SVH
`define PER_CPU_VECTOR_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define PVA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PVA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/pva_pkg.sv
// ----------------------------------------------------------------------------
// Per-CPU vector allocator package
// Request and response words, codes, sequencer states and helpers.
// ----------------------------------------------------------------------------
package pva_pkg;

	localparam int WORD_W        = 64;
	localparam int WORDS_PER_CPU = 4;
	localparam int VEC_COUNT     = 256;
	localparam int CNT_W         = 9;

	localparam logic [1:0] MODE_TARGET = 2'd0;
	localparam logic [1:0] MODE_LEAST  = 2'd1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_FREE = 2'd1;
	localparam logic [1:0] ST_RANGE   = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [2:0] target_cpu;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] vector;
		logic [2:0] chosen_cpu;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_WORD_RD,
		S_WORD_CHK,
		S_BIT_FIND,
		S_CNT_UPD
	} state_t;

	function automatic logic [2:0] lowest_set8(input logic [7:0] v);
		logic [2:0] idx;
		idx = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (v[i]) begin
				idx = 3'(i);
			end
		end
		return idx;
	endfunction

endpackage

### src/per_cpu_vector_allocator.sv
// ----------------------------------------------------------------------------
// Per-CPU interrupt vector allocator
// Bitmap allocator over one 256-bit vector map and one count per CPU.
// ----------------------------------------------------------------------------
// Usage:
//   A request word (req) is taken when start is high and busy is low. Each
//   request produces one response word (rsp), shown for one cycle with done.
//   The receiver cannot stall; done comes with busy low, so the next start
//   may be issued in the cycle that done is high. active_cpus is written
//   whenever active_cpus_we is high; the user, not the block, keeps it to idle.
// Steps from accept to done, as the sequencer walks the two RAMs:
//   reinitialize: answered from idle (per-word valid flags drop at once).
//   target cpu:   word read and check per word up to one with a free bit,
//                 then bit find, count update; out of range: done from idle.
//   least loaded: a count read and check per active cpu, then as above.
//   Requests run one at a time; none is taken while one is in progress.
// Reset: every bitmap word and count reads as its reserved-low default
// through cleared valid flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
module per_cpu_vector_allocator
	import pva_pkg::*;
#(
	parameter int MAX_CPUS         = 8,
	parameter int RESERVED_VECTORS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       active_cpus_we,
	input  logic [3:0] active_cpus,
	input  logic       start,
	output logic       busy,
	input  req_t       req,
	output logic       done,
	output rsp_t       rsp
);

`include "per_cpu_vector_allocator_macros.svh"

	localparam int CPU_W    = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
	localparam int NCNT_W   = $clog2(MAX_CPUS + 1);
	localparam int BM_DEPTH = MAX_CPUS * WORDS_PER_CPU;
	localparam int BM_AW    = (BM_DEPTH > 1) ? $clog2(BM_DEPTH) : 1;
	localparam logic [CNT_W-1:0] RST_CNT = CNT_W'(RESERVED_VECTORS);

	function automatic logic [WORDS_PER_CPU-1:0][WORD_W-1:0] rst_words();
		logic [WORDS_PER_CPU-1:0][WORD_W-1:0] r;
		for (int w = 0; w < WORDS_PER_CPU; w++) begin
			for (int b = 0; b < WORD_W; b++) begin
				r[w][b] = ((w * WORD_W + b) < RESERVED_VECTORS);
			end
		end
		return r;
	endfunction

	localparam logic [WORDS_PER_CPU-1:0][WORD_W-1:0] RST_WORDS = rst_words();

	state_t state_q, state_d;
	logic   done_q, done_d;
	rsp_t   rsp_q, rsp_d;
	logic [3:0] active_q;
	logic [BM_DEPTH-1:0] word_vld_q, word_vld_d;
	logic [MAX_CPUS-1:0] cnt_vld_q, cnt_vld_d;

	logic [CPU_W-1:0]  cpu_q, cpu_d;
	logic [1:0]        w_q, w_d;
	logic [NCNT_W-1:0] c_q, c_d;
	logic [CPU_W-1:0]  best_q, best_d;
	logic [CNT_W-1:0]  best_cnt_q, best_cnt_d;
	logic              found_q, found_d;
	logic [WORD_W-1:0] word_q, word_d;
	logic [2:0]        byte_q, byte_d;
	logic [7:0]        vec_q, vec_d;

	logic [NCNT_W-1:0] n_eff;
	logic [BM_AW-1:0]  baddr;
	logic [CPU_W-1:0]  caddr;
	logic [WORD_W-1:0] bm_rdata, bm_wdata, word_cur, free;
	logic [CNT_W-1:0]  cnt_rdata, cnt_wdata, cnt_cur;
	logic              bm_we, cnt_we;
	logic [7:0]        byte_free;
	logic [2:0]        bit_idx;
	logic [NCNT_W-1:0] c_next;

	always_comb begin
		if (active_q == 4'd0) begin
			n_eff = NCNT_W'(1);
		end else if (32'(active_q) > MAX_CPUS) begin
			n_eff = NCNT_W'(MAX_CPUS);
		end else begin
			n_eff = NCNT_W'(active_q);
		end
	end

	assign baddr = BM_AW'({cpu_q, w_q});
	assign caddr = (state_q == S_SCAN_RD || state_q == S_SCAN_CHK) ? c_q[CPU_W-1:0] : cpu_q;

	assign word_cur  = word_vld_q[baddr] ? bm_rdata : RST_WORDS[w_q];
	assign cnt_cur   = cnt_vld_q[caddr] ? cnt_rdata : RST_CNT;
	assign free      = ~word_cur;
	assign byte_free = ~word_q[{byte_q, 3'b000} +: 8];
	assign bit_idx   = lowest_set8(byte_free);
	assign bm_wdata  = word_q | (WORD_W'(1) << {byte_q, bit_idx});
	assign cnt_wdata = cnt_cur + CNT_W'(1);
	assign c_next    = c_q + NCNT_W'(1);

	always_comb begin
		logic [7:0] byte_any;
		logic       hit;
		for (int i = 0; i < 8; i++) begin
			byte_any[i] = |free[i*8 +: 8];
		end
		hit = 1'b0;

		state_d    = state_q;
		done_d     = 1'b0;
		rsp_d      = rsp_q;
		word_vld_d = word_vld_q;
		cnt_vld_d  = cnt_vld_q;
		cpu_d      = cpu_q;
		w_d        = w_q;
		c_d        = c_q;
		best_d     = best_q;
		best_cnt_d = best_cnt_q;
		found_d    = found_q;
		word_d     = word_q;
		byte_d     = byte_q;
		vec_d      = vec_q;
		bm_we      = 1'b0;
		cnt_we     = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (req.mode == MODE_TARGET) begin
						if (32'(req.target_cpu) >= 32'(n_eff)) begin
							done_d = 1'b1;
							rsp_d  = '{status: ST_RANGE, vector: 8'd0, chosen_cpu: 3'd0};
						end else begin
							cpu_d   = CPU_W'(req.target_cpu);
							w_d     = 2'd0;
							state_d = S_WORD_RD;
						end
					end else if (req.mode == MODE_LEAST) begin
						c_d     = '0;
						found_d = 1'b0;
						state_d = S_SCAN_RD;
					end else begin
						word_vld_d = '0;
						cnt_vld_d  = '0;
						done_d     = 1'b1;
						rsp_d      = '{status: ST_OK, vector: 8'd0, chosen_cpu: 3'd0};
					end
				end
			end
			S_SCAN_RD: begin
				state_d = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				hit = (cnt_cur < CNT_W'(VEC_COUNT)) && (!found_q || cnt_cur < best_cnt_q);
				if (hit) begin
					best_d     = c_q[CPU_W-1:0];
					best_cnt_d = cnt_cur;
					found_d    = 1'b1;
				end
				c_d = c_next;
				if (c_next == n_eff) begin
					if (hit || found_q) begin
						cpu_d   = hit ? c_q[CPU_W-1:0] : best_q;
						w_d     = 2'd0;
						state_d = S_WORD_RD;
					end else begin
						done_d  = 1'b1;
						rsp_d   = '{status: ST_NO_FREE, vector: 8'd0, chosen_cpu: 3'd0};
						state_d = S_IDLE;
					end
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_WORD_RD: begin
				state_d = S_WORD_CHK;
			end
			S_WORD_CHK: begin
				if (|free) begin
					word_d  = word_cur;
					byte_d  = lowest_set8(byte_any);
					state_d = S_BIT_FIND;
				end else if (w_q == 2'(WORDS_PER_CPU - 1)) begin
					done_d  = 1'b1;
					rsp_d   = '{status: ST_NO_FREE, vector: 8'd0, chosen_cpu: 3'd0};
					state_d = S_IDLE;
				end else begin
					w_d     = w_q + 2'd1;
					state_d = S_WORD_RD;
				end
			end
			S_BIT_FIND: begin
				bm_we             = 1'b1;
				word_vld_d[baddr] = 1'b1;
				vec_d             = {w_q, byte_q, bit_idx};
				state_d           = S_CNT_UPD;
			end
			S_CNT_UPD: begin
				cnt_we           = 1'b1;
				cnt_vld_d[caddr] = 1'b1;
				done_d           = 1'b1;
				rsp_d            = '{status: ST_OK, vector: vec_q, chosen_cpu: 3'(cpu_q)};
				state_d          = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			done_q     <= 1'b0;
			active_q   <= 4'd8;
			word_vld_q <= '0;
			cnt_vld_q  <= '0;
		end else begin
			state_q    <= state_d;
			done_q     <= done_d;
			word_vld_q <= word_vld_d;
			cnt_vld_q  <= cnt_vld_d;
			if (active_cpus_we) begin
				active_q <= active_cpus;
			end
		end
	end

	always_ff @(posedge clk) begin
		rsp_q      <= rsp_d;
		cpu_q      <= cpu_d;
		w_q        <= w_d;
		c_q        <= c_d;
		best_q     <= best_d;
		best_cnt_q <= best_cnt_d;
		found_q    <= found_d;
		word_q     <= word_d;
		byte_q     <= byte_d;
		vec_q      <= vec_d;
	end

	pva_ram #(
		.WIDTH (WORD_W),
		.DEPTH (BM_DEPTH),
		.AW    (BM_AW)
	) u_bitmap_ram (
		.clk   (clk),
		.we    (bm_we),
		.waddr (baddr),
		.wdata (bm_wdata),
		.raddr (baddr),
		.rdata (bm_rdata)
	);

	pva_ram #(
		.WIDTH (CNT_W),
		.DEPTH (MAX_CPUS),
		.AW    (CPU_W)
	) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (caddr),
		.wdata (cnt_wdata),
		.raddr (caddr),
		.rdata (cnt_rdata)
	);

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	`PVA_ASSERT_IMP(a_done_idle, done, !busy, "response while sequencer busy")
	`PVA_ASSERT_NXT(a_accept_progress, start && !busy, busy || done, "accepted word dropped")
	`PVA_ASSERT_IMP(a_fail_zero, done && rsp.status != ST_OK,
		rsp.vector == 8'd0 && rsp.chosen_cpu == 3'd0, "failed response carries data")
	`PVA_ASSERT_NXT(a_bitmap_write, bm_we, state_q == S_CNT_UPD, "count update skipped")

endmodule

### src/pva_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pva_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### test/tb_per_cpu_vector_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Per-CPU vector allocator testbench
// Drives request words from a queue and predicts every response word from a
// bitmap and count model kept per CPU. Runs directed corner requests, then
// random traffic biased to exhaust bitmaps, over several active-cpu settings
// and sender idle rates.
// ----------------------------------------------------------------------------
module tb_per_cpu_vector_allocator;
	import pva_pkg::*;

	localparam int         NUM_CPUS    = 8;
	localparam int         RESV        = 32;
	localparam int         CYCLE_LIMIT = 1000000;
	localparam int         DRAIN_WAIT  = 40;
	localparam logic [1:0] MODE_REINIT = 2'd2;
	localparam logic [1:0] MODE_SPARE  = 2'd3;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       active_cpus_we = 1'b0;
	logic [3:0] active_cpus = 4'd8;
	logic       start = 1'b0;
	logic       busy;
	req_t       req = '0;
	logic       done;
	rsp_t       rsp;

	req_t         request_queue[$];
	rsp_t         pending_grants[$];
	logic [255:0] vec_map [NUM_CPUS];
	logic [8:0]   vec_used [NUM_CPUS];
	logic [3:0]   cpu_limit;
	int           send_idle_pct = 0;
	int           cycle_count = 0;
	int           mismatches = 0;
	int           accepted = 0;
	int           n_alloc = 0;
	int           n_full = 0;
	int           n_range = 0;
	int           n_reinit = 0;
	int           n_settings = 0;

	per_cpu_vector_allocator u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.active_cpus_we (active_cpus_we),
		.active_cpus    (active_cpus),
		.start          (start),
		.busy           (busy),
		.req            (req),
		.done           (done),
		.rsp            (rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH cycle %0d: %s", cycle_count, what);
		mismatches++;
	endtask

	function automatic void reinit_maps();
		for (int c = 0; c < NUM_CPUS; c++) begin
			vec_map[c] = '0;
			for (int v = 0; v < RESV; v++) begin
				vec_map[c][v] = 1'b1;
			end
			vec_used[c] = 9'(RESV);
		end
	endfunction

	function automatic bit claim_lowest(input int cpu, output logic [7:0] vec);
		vec = '0;
		for (int v = 0; v < VEC_COUNT; v++) begin
			if (!vec_map[cpu][v]) begin
				vec_map[cpu][v] = 1'b1;
				vec_used[cpu] = vec_used[cpu] + 9'd1;
				vec = 8'(v);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic rsp_t alloc_outcome(input req_t r);
		rsp_t       res;
		int         n;
		int         best;
		int         best_count;
		bit         found;
		logic [7:0] vec;
		res = '0;
		n = int'(cpu_limit);
		if (n < 1) n = 1;
		if (n > NUM_CPUS) n = NUM_CPUS;
		if (r.mode == MODE_TARGET) begin
			if (int'(r.target_cpu) >= n) begin
				res.status = ST_RANGE;
			end else if (claim_lowest(int'(r.target_cpu), vec)) begin
				res.vector = vec;
				res.chosen_cpu = r.target_cpu;
			end else begin
				res.status = ST_NO_FREE;
			end
		end else if (r.mode == MODE_LEAST) begin
			best = 0;
			best_count = VEC_COUNT + 1;
			found = 1'b0;
			for (int c = 0; c < n; c++) begin
				if (int'(vec_used[c]) < VEC_COUNT && int'(vec_used[c]) < best_count) begin
					best_count = int'(vec_used[c]);
					best = c;
					found = 1'b1;
				end
			end
			if (found && claim_lowest(best, vec)) begin
				res.vector = vec;
				res.chosen_cpu = 3'(best);
			end else begin
				res.status = ST_NO_FREE;
			end
		end else begin
			reinit_maps();
		end
		return res;
	endfunction

	function automatic req_t random_request(input logic [2:0] focus);
		req_t r;
		int   roll;
		roll = $urandom_range(999);
		r.target_cpu = 3'($urandom_range(7));
		if (roll < 5) begin
			r.mode = (roll < 3) ? MODE_REINIT : MODE_SPARE;
		end else if (roll < 400) begin
			r.mode = MODE_LEAST;
		end else begin
			r.mode = MODE_TARGET;
			if (roll < 880) r.target_cpu = focus;
		end
		return r;
	endfunction

	task automatic push_req(input logic [1:0] mode, input logic [2:0] cpu);
		req_t r;
		r.mode = mode;
		r.target_cpu = cpu;
		request_queue = {request_queue, r};
	endtask

	task automatic drain();
		while (request_queue.size() != 0 || pending_grants.size() != 0 || busy) begin
			@(negedge clk);
		end
	endtask

	task automatic set_cpus(input logic [3:0] value, input int idle_pct);
		drain();
		@(posedge clk);
		active_cpus_we <= 1'b1;
		active_cpus <= value;
		@(posedge clk);
		active_cpus_we <= 1'b0;
		cpu_limit = value;
		send_idle_pct = idle_pct;
		n_settings++;
		@(negedge clk);
	endtask

	task automatic random_phase(input logic [3:0] cpus, input int idle_pct, input int count);
		logic [2:0] focus;
		set_cpus(cpus, idle_pct);
		focus = 3'($urandom_range(((cpus == 0) ? 1 : (cpus > 8 ? 8 : cpus)) - 1));
		for (int i = 0; i < count; i++) begin
			request_queue = {request_queue, random_request(focus)};
		end
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_per_cpu_vector_allocator NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				pending_grants = {pending_grants, alloc_outcome(req)};
				void'(request_queue.pop_front());
				accepted++;
				if (req.mode != MODE_TARGET && req.mode != MODE_LEAST) begin
					n_reinit++;
				end
			end
			if (start && busy) begin
				// hold the word until taken
			end else if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				start <= 1'b1;
				req <= request_queue[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : watch_results
		rsp_t want;
		if (arst_n && done) begin
			if (pending_grants.size() == 0) begin
				report_mismatch($sformatf("unexpected word status=%0d vector=%0d cpu=%0d",
					rsp.status, rsp.vector, rsp.chosen_cpu));
			end else begin
				want = pending_grants.pop_front();
				if (rsp.status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d", rsp.status, want.status));
				if (rsp.vector !== want.vector)
					report_mismatch($sformatf("vector %0d, want %0d", rsp.vector, want.vector));
				if (rsp.chosen_cpu !== want.chosen_cpu)
					report_mismatch($sformatf("chosen_cpu %0d, want %0d",
						rsp.chosen_cpu, want.chosen_cpu));
				case (want.status)
					ST_NO_FREE: n_full++;
					ST_RANGE:   n_range++;
					default:    n_alloc++;
				endcase
			end
		end
	end

	initial begin
		cpu_limit = 4'd8;
		reinit_maps();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_cpus(4'd8, 0);
		push_req(MODE_REINIT, 3'd0);
		push_req(MODE_SPARE, 3'd7);
		push_req(MODE_TARGET, 3'd0);
		push_req(MODE_TARGET, 3'd7);
		push_req(MODE_TARGET, 3'd0);
		push_req(MODE_LEAST, 3'd5);
		push_req(MODE_LEAST, 3'd0);
		push_req(MODE_LEAST, 3'd7);
		push_req(MODE_TARGET, 3'd3);
		push_req(MODE_LEAST, 3'd2);

		set_cpus(4'd0, 0);
		push_req(MODE_TARGET, 3'd0);
		push_req(MODE_TARGET, 3'd1);
		push_req(MODE_TARGET, 3'd7);
		push_req(MODE_LEAST, 3'd6);
		push_req(MODE_LEAST, 3'd1);

		set_cpus(4'd15, 0);
		push_req(MODE_TARGET, 3'd7);
		push_req(MODE_LEAST, 3'd4);
		push_req(MODE_REINIT, 3'd2);
		push_req(MODE_LEAST, 3'd3);

		set_cpus(4'd9, 0);
		push_req(MODE_TARGET, 3'd7);
		push_req(MODE_LEAST, 3'd7);

		random_phase(4'd1, 0, 300);
		random_phase(4'd2, 70, 350);
		random_phase(4'd8, 26, 500);
		random_phase(4'd15, 0, 330);
		random_phase(4'd0, 70, 150);
		random_phase(4'd5, 26, 250);
		drain();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (pending_grants.size() != 0)
			report_mismatch($sformatf("%0d words never returned", pending_grants.size()));

		$display("Ran %0d requests over %0d active-cpu settings: %0d allocations,",
			accepted, n_settings, n_alloc - n_reinit);
		$display("%0d full-map answers, %0d out-of-range answers, %0d reinitializations.",
			n_full, n_range, n_reinit);
		if (mismatches == 0) begin
			$display("tb_per_cpu_vector_allocator OK");
		end else begin
			$display("tb_per_cpu_vector_allocator NOT OK");
		end
		$finish;
	end

endmodule
